// ----- sv/stp_pkg.sv -----
// ----------------------------------------------------------------------------
// stp_pkg: shared types and constants of the shelf tile packer
// Request broadcast, cell control group, state encoding and register indexes.
// ----------------------------------------------------------------------------
package stp_pkg;

    localparam int COORD_W   = 14;   // atlas coordinates and sizes
    localparam int PTILE_W   = 15;   // padded tile size: 14-bit size plus twice the padding
    localparam int PAD_W     = 7;
    localparam int GRP_CELLS = 16;   // shelf cells reduced by one group stage

    localparam int unsigned ATLAS_RESET   = 4096;
    localparam int unsigned PADDING_RESET = 7;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [PTILE_W-1:0] ptile_t;
    typedef logic [PAD_W-1:0]   pad_t;

    // Register indexes of the configuration port.
    typedef enum logic [0:0] {
        REG_ATLAS_SIZE = 1'b0,
        REG_PADDING    = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIT,
        ST_GROUP,
        ST_DECIDE
    } state_t;

    // Request as seen by every shelf cell.
    typedef struct packed {
        ptile_t tw;
        ptile_t th;
        pad_t   pad;
        coord_t atlas;
    } req_t;

    // Control from the sequencer to the shelf cells.
    typedef struct packed {
        logic   eval;        // capture fit flag and candidate position
        logic   commit;      // the winning cell appends the tile to its row
        logic   open_shelf;  // the cell at the shelf count opens a new shelf
        coord_t new_top;     // top row of the new shelf
    } cell_ctl_t;

endpackage

// ----- sv/shelf_tile_packer.sv -----
// ----------------------------------------------------------------------------
// shelf_tile_packer: first-fit shelf packing of tiles into a square atlas
//
//   channel   signals                              direction
//   request   in_valid/in_ready, tile_width/height in
//   result    out_valid/out_ready, placed, pos_*   out
//   config    cfg_write, cfg_addr, cfg_data        in (write only)
//
// After acceptance each request passes through the fit, group and decide
// states before the next acceptance: every shelf cell compares in parallel,
// then the group priority stage, then final priority and the shelf update.
// The result sits in an output register; a stalled result holds the block in
// its decide step until the result register frees up. Reset clears the shelf
// count and the free row; shelf cells need no clearing.
// ----------------------------------------------------------------------------
module shelf_tile_packer #(
    parameter int MAX_SHELVES = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  stp_pkg::coord_t      tile_width,
    input  stp_pkg::coord_t      tile_height,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 placed,
    output stp_pkg::coord_t      pos_x,
    output stp_pkg::coord_t      pos_y,
    input  logic                 cfg_write,
    input  stp_pkg::cfg_reg_t    cfg_addr,
    input  stp_pkg::coord_t      cfg_data
);
    import stp_pkg::*;

    localparam int CNT_W     = $clog2(MAX_SHELVES + 1);
    localparam int NUM_GRP   = (MAX_SHELVES + GRP_CELLS - 1) / GRP_CELLS;
    localparam int NUM_CELLS = NUM_GRP * GRP_CELLS;

    state_t state_reg, state_next;

    coord_t atlas_reg, atlas_next;
    pad_t   pad_reg, pad_next;

    ptile_t tw_reg, th_reg, tw_next, th_next;
    logic [CNT_W-1:0] count_reg, count_next;
    coord_t nfr_reg, nfr_next;

    logic   out_valid_reg, out_valid_next;
    logic   placed_reg, placed_next;
    coord_t pos_x_reg, pos_y_reg, pos_x_next, pos_y_next;

    req_t      req;
    cell_ctl_t ctl;
    logic      accept, advance, oversize, hit, open_ok, res_placed;
    logic      eval_en, group_en;
    coord_t    hit_x, hit_y;

    logic                  cell_fit [NUM_CELLS];
    coord_t                cell_x   [NUM_CELLS];
    coord_t                cell_y   [NUM_CELLS];
    logic [NUM_GRP-1:0]    grp_hit, grp_first;
    logic [GRP_CELLS-1:0]  grp_sel  [NUM_GRP];
    coord_t                grp_x    [NUM_GRP];
    coord_t                grp_y    [NUM_GRP];

    assign req.tw    = tw_reg;
    assign req.th    = th_reg;
    assign req.pad   = pad_reg;
    assign req.atlas = atlas_reg;

    assign accept  = in_valid && in_ready;
    assign advance = !out_valid_reg || out_ready;

    // Shelf cells and group stages.
    for (genvar g = 0; g < NUM_GRP; g++)
    begin : g_grp
        logic [GRP_CELLS-1:0] fit_vec;
        coord_t               x_vec [GRP_CELLS];
        coord_t               y_vec [GRP_CELLS];

        for (genvar j = 0; j < GRP_CELLS; j++)
        begin : g_cell
            localparam int IDX = g * GRP_CELLS + j;
            if (IDX < MAX_SHELVES)
            begin : g_real
                stp_cell #(
                    .CNT_W (CNT_W)
                ) u_cell (
                    .clk         (clk),
                    .rst_n       (rst_n),
                    .req         (req),
                    .ctl         (ctl),
                    .cell_idx    (CNT_W'(IDX)),
                    .shelf_count (count_reg),
                    .win         (grp_first[g] && grp_sel[g][j]),
                    .fit         (cell_fit[IDX]),
                    .cand_x      (cell_x[IDX]),
                    .cand_y      (cell_y[IDX])
                );
            end
            else
            begin : g_none
                assign cell_fit[IDX] = 1'b0;
                assign cell_x[IDX]   = '0;
                assign cell_y[IDX]   = '0;
            end
            assign fit_vec[j] = cell_fit[IDX];
            assign x_vec[j]   = cell_x[IDX];
            assign y_vec[j]   = cell_y[IDX];
        end

        stp_group u_group (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (group_en),
            .fit    (fit_vec),
            .cand_x (x_vec),
            .cand_y (y_vec),
            .hit    (grp_hit[g]),
            .sel    (grp_sel[g]),
            .pos_x  (grp_x[g]),
            .pos_y  (grp_y[g])
        );
    end

    // Final priority stage over the groups.
    always_comb
    begin
        grp_first = grp_hit & ~(grp_hit - NUM_GRP'(1));
        hit_x = '0;
        hit_y = '0;
        for (int g = 0; g < NUM_GRP; g++)
        begin
            hit_x = hit_x | ({COORD_W{grp_first[g]}} & grp_x[g]);
            hit_y = hit_y | ({COORD_W{grp_first[g]}} & grp_y[g]);
        end
        oversize = (tw_reg > {1'b0, atlas_reg}) || (th_reg > {1'b0, atlas_reg});
        hit      = !oversize && (|grp_hit);
        open_ok  = !oversize && !hit && (count_reg < CNT_W'(MAX_SHELVES))
                   && ((16'(nfr_reg) + 16'(th_reg)) <= 16'(atlas_reg));
        res_placed = hit || open_ok;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_FIT;
                end
            end
            ST_FIT:    state_next = ST_GROUP;
            ST_GROUP:  state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                if (advance)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_ready       = 1'b0;
        eval_en        = 1'b0;
        group_en       = 1'b0;
        ctl.eval       = 1'b0;
        ctl.commit     = 1'b0;
        ctl.open_shelf = 1'b0;
        ctl.new_top    = nfr_reg;
        unique case (state_reg)
            ST_IDLE:   in_ready = 1'b1;
            ST_FIT:    eval_en  = 1'b1;
            ST_GROUP:  group_en = 1'b1;
            ST_DECIDE:
            begin
                ctl.commit     = advance && hit;
                ctl.open_shelf = advance && open_ok;
            end
            default:   in_ready = 1'b0;
        endcase
        ctl.eval = eval_en;
    end

    // Datapath registers.
    always_comb
    begin
        tw_next        = tw_reg;
        th_next        = th_reg;
        count_next     = count_reg;
        nfr_next       = nfr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        placed_next    = placed_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        atlas_next     = atlas_reg;
        pad_next       = pad_reg;

        if (accept)
        begin
            tw_next = PTILE_W'(tile_width)  + PTILE_W'({pad_reg, 1'b0});
            th_next = PTILE_W'(tile_height) + PTILE_W'({pad_reg, 1'b0});
        end

        if (ctl.open_shelf)
        begin
            count_next = count_reg + CNT_W'(1);
            nfr_next   = COORD_W'(16'(nfr_reg) + 16'(th_reg));
        end

        if ((state_reg == ST_DECIDE) && advance)
        begin
            out_valid_next = 1'b1;
            placed_next    = res_placed;
            if (hit)
            begin
                pos_x_next = hit_x;
                pos_y_next = hit_y;
            end
            else if (open_ok)
            begin
                pos_x_next = COORD_W'(pad_reg);
                pos_y_next = nfr_reg + COORD_W'(pad_reg);
            end
            else
            begin
                pos_x_next = '0;
                pos_y_next = '0;
            end
        end

        if (cfg_write)
        begin
            unique case (cfg_addr)
                REG_ATLAS_SIZE: atlas_next = cfg_data;
                REG_PADDING:    pad_next   = cfg_data[PAD_W-1:0];
                default:        atlas_next = atlas_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            nfr_reg       <= '0;
            out_valid_reg <= 1'b0;
            atlas_reg     <= COORD_W'(ATLAS_RESET);
            pad_reg       <= PAD_W'(PADDING_RESET);
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            nfr_reg       <= nfr_next;
            out_valid_reg <= out_valid_next;
            atlas_reg     <= atlas_next;
            pad_reg       <= pad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tw_reg     <= tw_next;
        th_reg     <= th_next;
        placed_reg <= placed_next;
        pos_x_reg  <= pos_x_next;
        pos_y_reg  <= pos_y_next;
    end

    assign out_valid = out_valid_reg;
    assign placed    = placed_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;

endmodule

// ----- sv/stp_cell.sv -----
// ----------------------------------------------------------------------------
// stp_cell: one shelf of the packer
// Holds top row, height and used width of one shelf and checks the request.
// ----------------------------------------------------------------------------
module stp_cell #(
    parameter int CNT_W = 9
) (
    input  logic              clk,
    input  logic              rst_n,
    input  stp_pkg::req_t     req,
    input  stp_pkg::cell_ctl_t ctl,
    input  logic [CNT_W-1:0]  cell_idx,
    input  logic [CNT_W-1:0]  shelf_count,
    input  logic              win,
    output logic              fit,
    output stp_pkg::coord_t   cand_x,
    output stp_pkg::coord_t   cand_y
);
    import stp_pkg::*;

    coord_t top_reg, tall_reg, fill_reg;
    coord_t top_next, tall_next, fill_next;
    logic   fit_reg, fit_next;
    coord_t cand_x_reg, cand_y_reg;
    coord_t slack;
    logic   active, tall_ok, room_ok;

    always_comb
    begin
        active  = cell_idx < shelf_count;
        tall_ok = {1'b0, tall_reg} >= req.th;
        room_ok = (16'(fill_reg) + 16'(req.tw)) <= 16'(req.atlas);
        fit_next = active && tall_ok && room_ok;
        // Only meaningful when the tile fits, so the height difference is never negative.
        slack = tall_reg - req.th[COORD_W-1:0];
    end

    always_comb
    begin
        top_next  = top_reg;
        tall_next = tall_reg;
        fill_next = fill_reg;
        if (ctl.commit && win)
        begin
            fill_next = COORD_W'(16'(fill_reg) + 16'(req.tw));
        end
        else if (ctl.open_shelf && (cell_idx == shelf_count))
        begin
            top_next  = ctl.new_top;
            tall_next = req.th[COORD_W-1:0];
            fill_next = req.tw[COORD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_reg <= 1'b0;
        end
        else if (ctl.eval)
        begin
            fit_reg <= fit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg  <= top_next;
        tall_reg <= tall_next;
        fill_reg <= fill_next;
        if (ctl.eval)
        begin
            cand_x_reg <= fill_reg + COORD_W'(req.pad);
            cand_y_reg <= top_reg + COORD_W'(req.pad) + (slack >> 1);
        end
    end

    assign fit    = fit_reg;
    assign cand_x = cand_x_reg;
    assign cand_y = cand_y_reg;

endmodule

// ----- sv/stp_group.sv -----
// ----------------------------------------------------------------------------
// stp_group: first-fit reduction over one group of shelf cells
// Finds the lowest fitting cell of the group and registers its position.
// ----------------------------------------------------------------------------
module stp_group (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic [stp_pkg::GRP_CELLS-1:0]    fit,
    input  stp_pkg::coord_t                  cand_x [stp_pkg::GRP_CELLS],
    input  stp_pkg::coord_t                  cand_y [stp_pkg::GRP_CELLS],
    output logic                             hit,
    output logic [stp_pkg::GRP_CELLS-1:0]    sel,
    output stp_pkg::coord_t                  pos_x,
    output stp_pkg::coord_t                  pos_y
);
    import stp_pkg::*;

    logic [GRP_CELLS-1:0] first_next, sel_reg;
    logic                 hit_reg;
    coord_t               x_next, y_next, x_reg, y_reg;

    always_comb
    begin
        // Isolate the lowest set bit: the earliest shelf that fits.
        first_next = fit & ~(fit - GRP_CELLS'(1));
        x_next = '0;
        y_next = '0;
        for (int j = 0; j < GRP_CELLS; j++)
        begin
            x_next = x_next | ({COORD_W{first_next[j]}} & cand_x[j]);
            y_next = y_next | ({COORD_W{first_next[j]}} & cand_y[j]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
            sel_reg <= '0;
        end
        else if (en)
        begin
            hit_reg <= |fit;
            sel_reg <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

    assign hit   = hit_reg;
    assign sel   = sel_reg;
    assign pos_x = x_reg;
    assign pos_y = y_reg;

endmodule

// ----- sv/stp_checker.sv -----
// ----------------------------------------------------------------------------
// stp_checker: port-level checks of the shelf tile packer
// Watches both channels and is bound to every instance of the top level.
// ----------------------------------------------------------------------------
module stp_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            out_valid,
    input logic            out_ready,
    input logic            placed,
    input stp_pkg::coord_t pos_x,
    input stp_pkg::coord_t pos_y
);
    import stp_pkg::*;

    // A result that was not placed carries a zero position.
    a_unplaced_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !placed) |-> (pos_x == '0 && pos_y == '0))
        else $error("unplaced result with nonzero position");

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(placed)
                                       && $stable(pos_x) && $stable(pos_y)))
        else $error("stalled result changed");

    // After a request is taken, the block is busy through its fit, group and decide steps.
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready ##1 !in_ready ##1 !in_ready)
        else $error("request taken during a search");

    // A new result only appears after the block has left the idle state.
    a_result_needs_req: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result without a request in flight");

endmodule

bind shelf_tile_packer stp_checker u_stp_checker (.*);

// ----- tb/shelf_tile_packer_test.sv -----
// ----------------------------------------------------------------------------
// shelf_tile_packer_test: self-checking testbench for the shelf tile packer
// Drives placement requests through the valid/ready ports and predicts every
// placement with a first-fit shelf model kept in the testbench. Covers
// degenerate and extreme atlas settings, oversize tiles, a full atlas, a full
// shelf table, long result back-pressure and random idling on both channels.
// ----------------------------------------------------------------------------
module shelf_tile_packer_test;

    timeunit 1ns;
    timeprecision 1ps;

    import stp_pkg::*;

    localparam int SHELF_SLOTS = 256;
    localparam int unsigned SIZE_MASK = 14'h3FFF;
    localparam int unsigned PAD_MASK  = 7'h7F;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic   placed;
        coord_t x;
        coord_t y;
    } placement_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    coord_t     tile_width;
    coord_t     tile_height;
    logic       out_valid;
    logic       out_ready;
    logic       placed;
    coord_t     pos_x;
    coord_t     pos_y;
    logic       cfg_write;
    cfg_reg_t   cfg_addr;
    coord_t     cfg_data;

    shelf_tile_packer #(
        .MAX_SHELVES (SHELF_SLOTS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .tile_width  (tile_width),
        .tile_height (tile_height),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .placed      (placed),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .cfg_write   (cfg_write),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data)
    );

    // Shadow copy of the atlas: shelves and the current register values.
    int unsigned shelf_row    [SHELF_SLOTS];
    int unsigned shelf_height [SHELF_SLOTS];
    int unsigned shelf_used   [SHELF_SLOTS];
    int unsigned shelves_open = 0;
    int unsigned free_row     = 0;
    int unsigned atlas_reg    = ATLAS_RESET;
    int unsigned pad_reg      = PADDING_RESET;

    placement_t pending_places[$];

    int errors         = 0;
    int requests_sent  = 0;
    int placed_seen    = 0;
    int rejected_seen  = 0;
    int send_idle_pct  = 14;
    int recv_idle_pct  = 83;
    int hold_request   = 0;
    int hold_served    = 0;
    int hold_left      = 0;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // First-fit shelf placement of one tile; updates the shadow atlas.
    function automatic placement_t place_tile(input coord_t w, input coord_t h);
        int unsigned tw;
        int unsigned th;
        int unsigned px;
        int unsigned py;
        int unsigned k;
        bit          ok;
        placement_t  r;
        tw = w + 2 * pad_reg;
        th = h + 2 * pad_reg;
        px = 0;
        py = 0;
        ok = 1'b0;
        if (tw <= atlas_reg && th <= atlas_reg)
        begin
            for (k = 0; k < shelves_open; k++)
            begin
                if (shelf_height[k] >= th && shelf_used[k] + tw <= atlas_reg)
                begin
                    px = shelf_used[k] + pad_reg;
                    py = shelf_row[k] + pad_reg + (shelf_height[k] - th) / 2;
                    shelf_used[k] = (shelf_used[k] + tw) & SIZE_MASK;
                    ok = 1'b1;
                    break;
                end
            end
            if (!ok && shelves_open < SHELF_SLOTS && free_row + th <= atlas_reg)
            begin
                shelf_row[shelves_open]    = free_row;
                shelf_height[shelves_open] = th;
                shelf_used[shelves_open]   = tw;
                shelves_open++;
                px = pad_reg;
                py = free_row + pad_reg;
                free_row = (free_row + th) & SIZE_MASK;
                ok = 1'b1;
            end
        end
        r.placed = ok;
        r.x      = ok ? coord_t'(px) : '0;
        r.y      = ok ? coord_t'(py) : '0;
        return r;
    endfunction

    // Mostly small tiles so shelves get shared, with some large and edge sizes.
    function automatic coord_t pick_size();
        coord_t v;
        case ($urandom_range(9))
            6, 7:    v = coord_t'($urandom_range(1024));
            8:       v = coord_t'($urandom_range(8192));
            9:
            begin
                case ($urandom_range(2))
                    0:       v = '0;
                    1:       v = coord_t'(8191);
                    default: v = coord_t'(8192);
                endcase
            end
            default: v = coord_t'($urandom_range(64));
        endcase
        return v;
    endfunction

    task automatic offer_tile(input coord_t w, input coord_t h);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        tile_width  <= w;
        tile_height <= h;
        do
            @(posedge clk);
        while (!in_ready);
        pending_places = {pending_places, place_tile(w, h)};
        requests_sent++;
    endtask

    // Stop offering, let every expected placement arrive, then let the
    // pipeline settle before anything else touches the block.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_places.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
        cfg_write <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= coord_t'(value);
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_ATLAS_SIZE)
            atlas_reg = value & SIZE_MASK;
        else
            pad_reg = value & PAD_MASK;
        @(posedge clk);
    endtask

    // Atlas of size zero and one: zero-size tiles, zero-height shelves and an
    // atlas that fills after a single row.
    task automatic test_degenerate_atlas();
        wait_drained();
        write_reg(REG_ATLAS_SIZE, 0);
        write_reg(REG_PADDING, 0);
        offer_tile(0, 0);
        offer_tile(1, 0);
        offer_tile(0, 0);
        offer_tile(0, 1);
        wait_drained();
        write_reg(REG_ATLAS_SIZE, 1);
        offer_tile(1, 1);
        offer_tile(1, 1);
        offer_tile(0, 0);
        wait_drained();
    endtask

    // Atlas of 8192 and padding of 64, field extremes, then back to the reset values.
    task automatic test_field_extremes();
        write_reg(REG_ATLAS_SIZE, 8192);
        write_reg(REG_PADDING, 64);
        offer_tile(8192, 0);
        offer_tile(0, 8192);
        offer_tile(8064, 8064);
        offer_tile(0, 0);
        offer_tile(8191, 8191);
        wait_drained();
        write_reg(REG_PADDING, 0);
        offer_tile(8192, 1);
        offer_tile(8191, 8192);
        wait_drained();
        write_reg(REG_ATLAS_SIZE, ATLAS_RESET);
        write_reg(REG_PADDING, PADDING_RESET);
        offer_tile(4082, 10);
        offer_tile(4083, 10);
        offer_tile(5, 3);
        offer_tile(10, 4082);
        offer_tile(2, 1);
        wait_drained();
    endtask

    task automatic test_random_mix(input int count, input int s_pct, input int r_pct,
                                   input int unsigned atlas, input int unsigned pad);
        wait_drained();
        write_reg(REG_ATLAS_SIZE, atlas);
        write_reg(REG_PADDING, pad);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (count) offer_tile(pick_size(), pick_size());
        wait_drained();
    endtask

    // The result side stalls for a long stretch while requests keep coming,
    // so the block backs up and must hold off its request channel.
    task automatic test_result_backpressure();
        hold_request++;
        repeat (40) offer_tile(pick_size(), pick_size());
        wait_drained();
    endtask

    // Mostly wide, shallow tiles open new shelves until the shelf
    // table runs out; after that only existing shelves can take tiles.
    task automatic test_shelf_table_full();
        wait_drained();
        write_reg(REG_ATLAS_SIZE, 8192);
        write_reg(REG_PADDING, 0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (500)
        begin
            if ($urandom_range(9) < 8)
                offer_tile(coord_t'($urandom_range(2048, 8192)), coord_t'($urandom_range(8)));
            else
                offer_tile(pick_size(), pick_size());
        end
        wait_drained();
    endtask

    always @(posedge clk)
    begin
        if (hold_request != hold_served)
        begin
            hold_served = hold_request;
            hold_left   = HOLD_CYCLES;
        end
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        placement_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_places.size() == 0)
            begin
                $display("%0t: unexpected result placed=%0b x=%0d y=%0d",
                         $time, placed, pos_x, pos_y);
                errors++;
            end
            else
            begin
                want = pending_places.pop_front();
                if (placed) placed_seen++; else rejected_seen++;
                if (placed !== want.placed)
                begin
                    $display("%0t: placed expected %0b actual %0b", $time, want.placed, placed);
                    errors++;
                end
                if (pos_x !== want.x)
                begin
                    $display("%0t: pos_x expected %0d actual %0d", $time, want.x, pos_x);
                    errors++;
                end
                if (pos_y !== want.y)
                begin
                    $display("%0t: pos_y expected %0d actual %0d", $time, want.y, pos_y);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #10ms;
        $display("%0t: timeout with %0d results outstanding", $time, pending_places.size());
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        tile_width  = '0;
        tile_height = '0;
        cfg_write   = 1'b0;
        cfg_addr    = REG_ATLAS_SIZE;
        cfg_data    = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_degenerate_atlas();
        test_field_extremes();
        test_random_mix(450, 14, 83, 4096, 7);
        test_result_backpressure();
        test_random_mix(450, 83, 14, 512, 2);
        test_shelf_table_full();
        test_random_mix(400, 0, 0, 6000, 1);

        $display("Sent %0d tile requests: %0d placed, %0d rejected, %0d shelves open.",
                 requests_sent, placed_seen, rejected_seen, shelves_open);
        $display("Atlas sizes 0 to 8192, padding 0 to 64, long result stall included.");
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/stp_pkg.sv
sv/stp_cell.sv
sv/stp_group.sv
sv/shelf_tile_packer.sv
sv/stp_checker.sv
tb/shelf_tile_packer_test.sv
